>>> rtl/udec_pkg.sv
// shared types and constants of the binary to decimal ascii converter
package udec_pkg;

	localparam int VALUE_BITS = 64;
	localparam int IN_BITS    = 64;
	localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_BITS   = NUM_DIGITS * 4;
	localparam int CNT_BITS   = $clog2(VALUE_BITS);
	localparam int DIG_BITS   = $clog2(NUM_DIGITS + 1);
	localparam int CHAR_BITS  = 6;

	localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 6'd48;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} udec_state_t;

	typedef struct packed {
		logic load;
		logic conv;
		logic skip;
		logic emit;
	} udec_cmd_t;

	typedef struct packed {
		logic conv_done;
		logic top_zero;
		logic last_digit;
	} udec_status_t;

endpackage

>>> rtl/udec_ctrl.sv
// controller state machine of the binary to decimal ascii converter
module udec_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  udec_pkg::udec_status_t status,
	output udec_pkg::udec_cmd_t    cmd,
	output logic                  busy
);
	import udec_pkg::*;

	udec_state_t state_q;
	udec_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_next = ST_CONV;
			end
			ST_CONV: begin
				if (status.conv_done) state_next = ST_SKIP;
			end
			ST_SKIP: begin
				if (!status.top_zero || status.last_digit) state_next = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.last_digit) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
			end
			ST_SKIP: begin
				cmd.skip = status.top_zero && !status.last_digit;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

>>> rtl/udec_dp.sv
// datapath: bit-serial double dabble and digit output registers
module udec_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [udec_pkg::IN_BITS-1:0]   value,
	input  udec_pkg::udec_cmd_t            cmd,
	output udec_pkg::udec_status_t         status,
	output logic                           strobe,
	output logic [udec_pkg::CHAR_BITS-1:0] digit_char,
	output logic                           last
);
	import udec_pkg::*;

	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic [BCD_BITS-1:0]   bcd_adj;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [DIG_BITS-1:0]   dig_q;
	logic [3:0]            top_nib;
	logic                  strobe_q;
	logic [CHAR_BITS-1:0]  digit_q;
	logic                  last_q;

	// add three to every digit of five or more
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	assign top_nib           = bcd_q[BCD_BITS-1 -: 4];
	assign status.conv_done  = (cnt_q == CNT_BITS'(VALUE_BITS - 1));
	assign status.top_zero   = (top_nib == 4'd0);
	assign status.last_digit = (dig_q == DIG_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			dig_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.load) begin
				cnt_q <= '0;
				dig_q <= DIG_BITS'(NUM_DIGITS);
			end else if (cmd.conv) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end else if (cmd.skip || cmd.emit) begin
				dig_q <= dig_q - DIG_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value[VALUE_BITS-1:0];
			bcd_q <= '0;
		end else if (cmd.conv) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_BITS-2:0], bin_q[VALUE_BITS-1]};
		end else if (cmd.skip || cmd.emit) begin
			bcd_q <= {bcd_q[BCD_BITS-5:0], 4'd0};
		end
		if (cmd.emit) begin
			digit_q <= CHAR_ZERO + {{(CHAR_BITS-4){1'b0}}, top_nib};
			last_q  <= status.last_digit;
		end
	end

	assign strobe     = strobe_q;
	assign digit_char = digit_q;
	assign last       = last_q;

endmodule

>>> rtl/unsigned_to_decimal_ascii.sv
// top level of the binary to decimal ascii converter
//
// input: drive value and pulse start; the item is taken on a clock edge with
// start high and busy low. busy stays high until the final digit is out.
// output: the item result as ascii digits, most significant first, no leading
// zeros, a zero value giving the single digit '0'. each digit sits on
// digit_char for one cycle with strobe high; last marks the final digit.
// the receiver cannot stall, so every strobe must be taken as it comes.
// timing: bit-serial double dabble over VALUE_BITS input bits (one input bit per
// cycle through the bcd shift register), then each leading zero digit is
// skipped (up to NUM_DIGITS-1 of them) and the first digit is reached, then the
// digits are emitted one by one. each digit passes through an output register
// before it shows on digit_char. a new start is taken only while busy is low,
// so a new item is not accepted until the last digit of the previous one has
// been emitted.
// reset: arst_n clears the controller to idle and drops strobe at once.
module unsigned_to_decimal_ascii (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [udec_pkg::IN_BITS-1:0]   value,
	output logic                           strobe,
	output logic [udec_pkg::CHAR_BITS-1:0] digit_char,
	output logic                           last
);
	import udec_pkg::*;

	udec_cmd_t    cmd;
	udec_status_t status;

	udec_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	udec_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.status     (status),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last       (last)
	);

	// accepted item starts work
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted item");

	// no digit strobe while converting has just begun
	a_rise_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !strobe)
		else $error("digit strobed at start of a new item");

	// a digit other than the final one only comes while busy
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final digit while idle");

	// the final digit ends the burst
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("digit after final digit");

	// digits are decimal
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (digit_char >= CHAR_ZERO) && (digit_char <= CHAR_ZERO + 6'd9))
		else $error("digit out of decimal range");

endmodule
